FILE: src/dlls_pkg.sv
// Shared types, codes and exp tables for the dense layer unit.
// No dependencies; imported by every module of the block.
package dlls_pkg;

  localparam int VAL_W = 16;
  localparam int ACC_W = 40;
  localparam int NUM_W = 30;
  localparam int DIV_CNT_W = 5;

  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_BIAS   = 2'd1;
  localparam logic [1:0] CMD_ACT    = 2'd2;

  localparam logic [1:0] REG_ACT_MODE  = 2'd0;
  localparam logic [1:0] REG_OUT_COUNT = 2'd1;
  localparam logic [1:0] REG_SLOPE     = 2'd2;

  typedef enum logic [1:0] {
    MODE_LEAKY = 2'd0,
    MODE_MAX   = 2'd1,
    MODE_TOTAL = 2'd2,
    MODE_SOFT  = 2'd3
  } sum_mode_t;

  typedef struct packed {
    logic      bias_rd;
    logic      empty;
    logic      mac;
    logic      mac_end;
    logic      sum_rd;
    sum_mode_t mode;
    logic      first;
    logic      last;
    logic      clr_len;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

  function automatic logic [16:0] exp_int_q16(input logic [3:0] k);
    logic [16:0] r;
    unique case (k)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd24109;
      4'd2:    r = 17'd8869;
      4'd3:    r = 17'd3263;
      4'd4:    r = 17'd1200;
      4'd5:    r = 17'd442;
      4'd6:    r = 17'd162;
      4'd7:    r = 17'd60;
      4'd8:    r = 17'd22;
      4'd9:    r = 17'd8;
      4'd10:   r = 17'd3;
      4'd11:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] exp_frac_q16(input logic [3:0] k);
    logic [16:0] r;
    unique case (k)
      4'd0:  r = 17'd65536;
      4'd1:  r = 17'd61565;
      4'd2:  r = 17'd57835;
      4'd3:  r = 17'd54331;
      4'd4:  r = 17'd51039;
      4'd5:  r = 17'd47947;
      4'd6:  r = 17'd45042;
      4'd7:  r = 17'd42313;
      4'd8:  r = 17'd39750;
      4'd9:  r = 17'd37341;
      4'd10: r = 17'd35079;
      4'd11: r = 17'd32954;
      4'd12: r = 17'd30957;
      4'd13: r = 17'd29081;
      4'd14: r = 17'd27319;
      4'd15: r = 17'd25664;
    endcase
    return r;
  endfunction

endpackage

FILE: src/dlls_dp.sv
// Datapath of the dense layer unit: stores, MAC pipeline, leaky ReLU,
// softmax weight pipeline and serial divider. Depends on dlls_pkg.
module dlls_dp
  import dlls_pkg::*;
#(
  parameter int OUT_MAX = 64,
  parameter int IN_MAX  = 256,
  parameter int ROW_W   = 6,
  parameter int AW      = 8,
  parameter int LEN_W   = 9
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  dp_cmd_t                 cmd,
  input  logic [ROW_W-1:0]        idx,
  input  logic [AW-1:0]           col_sel,
  input  logic [15:0]             slope,
  input  logic [1:0]              command,
  input  logic [5:0]              row,
  input  logic [7:0]              col,
  input  logic signed [VAL_W-1:0] value,
  output logic [LEN_W-1:0]        len,
  output dp_stat_t                stat,
  output logic                    strobe,
  output logic [5:0]              out_index,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_last
);

  localparam int WDEPTH = OUT_MAX * IN_MAX;
  localparam int WA_W   = WDEPTH > 1 ? $clog2(WDEPTH) : 1;
  localparam int TOT_W  = 17 + $clog2(OUT_MAX);

  logic signed [VAL_W-1:0] wmem [WDEPTH];
  logic signed [VAL_W-1:0] amem [IN_MAX];
  logic signed [VAL_W-1:0] bmem [OUT_MAX];
  logic signed [ACC_W-1:0] smem [OUT_MAX];
  logic [OUT_MAX-1:0]      bvalid;

  logic            w_we, b_we, a_we;
  logic [WA_W-1:0] w_wa, w_ra;

  always_comb begin
    w_we = accept && command == CMD_WEIGHT && 32'(row) < OUT_MAX && 32'(col) < IN_MAX;
    b_we = accept && command == CMD_BIAS && 32'(row) < OUT_MAX;
    a_we = accept && command == CMD_ACT && 32'(col) < IN_MAX;
    w_wa = WA_W'(32'(row) * IN_MAX + 32'(col));
    w_ra = WA_W'(32'(idx) * IN_MAX + 32'(col_sel));
  end

  // stores
  logic signed [VAL_W-1:0] w_q, a_q, b_q;
  logic                    bv_q;

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_wa] <= value;
    end
    w_q <= wmem[w_ra];
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      amem[AW'(col)] <= value;
    end
    a_q <= amem[col_sel];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bmem[ROW_W'(row)] <= value;
    end
    b_q  <= bmem[idx];
    bv_q <= bvalid[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= '0;
    end else if (b_we) begin
      bvalid[ROW_W'(row)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (cmd.clr_len) begin
      len <= '0;
    end else if (accept && command == CMD_ACT && len < LEN_W'(IN_MAX)) begin
      len <= len + 1'b1;
    end
  end

  // MAC pipeline
  logic                    b1_v, b1_empty, m1_v, m1_end, m2_v, m2_end;
  logic [ROW_W-1:0]        b1_idx, m1_idx, m2_idx;
  logic signed [31:0]      prod;
  logic signed [ACC_W-1:0] acc, bias_ext, acc_sat;
  logic signed [ACC_W:0]   acc_sum;

  always_comb begin
    bias_ext = bv_q ? {{12{b_q[15]}}, b_q, 12'b0} : '0;
    acc_sum  = {acc[ACC_W-1], acc} + {{(ACC_W-31){prod[31]}}, prod};
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
      m1_v <= 1'b0;
      m2_v <= 1'b0;
    end else begin
      b1_v <= cmd.bias_rd;
      m1_v <= cmd.mac;
      m2_v <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    b1_empty <= cmd.empty;
    b1_idx   <= idx;
    m1_end   <= cmd.mac_end;
    m1_idx   <= idx;
    m2_end   <= m1_end;
    m2_idx   <= m1_idx;
    prod     <= w_q * a_q;
    if (b1_v) begin
      acc <= bias_ext;
    end else if (m2_v) begin
      acc <= acc_sat;
    end
  end

  // sum store
  logic signed [ACC_W-1:0] s_q;

  always_ff @(posedge clk) begin
    if (b1_v && b1_empty) begin
      smem[b1_idx] <= bias_ext;
    end else if (m2_v && m2_end) begin
      smem[m2_idx] <= acc_sat;
    end
    s_q <= smem[idx];
  end

  // activation pipeline
  logic             s1_v, s2_v, s3_v, s4_v;
  sum_mode_t        s1_mode, s2_mode, s3_mode, s4_mode;
  logic [ROW_W-1:0] s1_idx, s2_idx, s3_idx, s4_idx;
  logic             s1_first, s2_first, s3_first, s4_first;
  logic             s1_last, s2_last, s3_last, s4_last;

  logic signed [ACC_W-1:0] mx, sy;
  logic signed [56:0]      pl;
  logic                    neg, z2, z3;
  logic [33:0]             p1, p2;
  logic [7:0]              lo8;
  logic [16:0]             w;
  logic [TOT_W-1:0]        total;

  logic [ACC_W:0]          diff;
  logic [28:0]             dq;
  logic                    zero;
  logic [34:0]             t1, t2;
  logic [16:0]             e1, f2;
  logic signed [40:0]      y;
  logic signed [41:0]      yr;
  logic signed [29:0]      yq;
  logic signed [VAL_W-1:0] y_sat;

  always_comb begin
    diff  = {mx[ACC_W-1], mx} - {s_q[ACC_W-1], s_q};
    dq    = diff[ACC_W:12];
    zero  = (dq[28:16] != '0) || (dq[15:12] >= 4'd12);
    t1    = 35'(p1) + 35'd32768;
    e1    = t1[32:16];
    f2    = 17'd65536 - {5'b0, lo8, 4'b0};
    t2    = 35'(p2) + 35'd32768;
    y     = neg ? $signed(pl[56:16]) : {sy[ACC_W-1], sy};
    yr    = {y[40], y} + 42'sd2048;
    yq    = $signed(yr[41:12]);
    if (yq > 30'sd32767) begin
      y_sat = 16'sh7fff;
    end else if (yq < -30'sd32768) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = yq[15:0];
    end
  end

  // divider
  logic                 div_busy;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [NUM_W-1:0]     num, num_next;
  logic [TOT_W-1:0]     rem, rem_next;
  logic [TOT_W:0]       trial;
  logic                 ge;
  logic [5:0]           d_index;
  logic                 d_last;

  always_comb begin
    trial    = {rem, num[NUM_W-1]};
    ge       = trial >= {1'b0, total};
    rem_next = ge ? TOT_W'(trial - {1'b0, total}) : trial[TOT_W-1:0];
    num_next = {num[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v          <= 1'b0;
      s2_v          <= 1'b0;
      s3_v          <= 1'b0;
      s4_v          <= 1'b0;
      div_busy      <= 1'b0;
      strobe        <= 1'b0;
      stat.div_done <= 1'b0;
    end else begin
      s1_v          <= cmd.sum_rd;
      s2_v          <= s1_v && s1_mode != MODE_MAX;
      s3_v          <= s2_v && s2_mode != MODE_LEAKY;
      s4_v          <= s3_v;
      strobe        <= 1'b0;
      stat.div_done <= 1'b0;
      if (s2_v && s2_mode == MODE_LEAKY) begin
        strobe <= 1'b1;
      end
      if (s4_v && s4_mode == MODE_SOFT) begin
        div_busy <= 1'b1;
      end else if (div_busy && div_cnt == DIV_CNT_W'(NUM_W - 1)) begin
        div_busy      <= 1'b0;
        strobe        <= 1'b1;
        stat.div_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_mode  <= cmd.mode;
    s1_idx   <= idx;
    s1_first <= cmd.first;
    s1_last  <= cmd.last;
    s2_mode  <= s1_mode;
    s2_idx   <= s1_idx;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s3_mode  <= s2_mode;
    s3_idx   <= s2_idx;
    s3_first <= s2_first;
    s3_last  <= s2_last;
    s4_mode  <= s3_mode;
    s4_idx   <= s3_idx;
    s4_first <= s3_first;
    s4_last  <= s3_last;

    pl  <= s_q * $signed({1'b0, slope});
    sy  <= s_q;
    neg <= s_q[ACC_W-1];
    p1  <= 34'(exp_int_q16(dq[15:12])) * 34'(exp_frac_q16(dq[11:8]));
    lo8 <= dq[7:0];
    z2  <= zero;
    p2  <= 34'(e1) * 34'(f2);
    z3  <= z2;
    w   <= z3 ? 17'd0 : t2[32:16];

    if (s1_v && s1_mode == MODE_MAX && (s1_first || s_q > mx)) begin
      mx <= s_q;
    end

    if (s2_v && s2_mode == MODE_LEAKY) begin
      out_index <= 6'(s2_idx);
      out_value <= y_sat;
      out_last  <= s2_last;
    end

    if (s4_v && s4_mode == MODE_TOTAL) begin
      total <= s4_first ? TOT_W'(w) : total + TOT_W'(w);
    end

    if (s4_v && s4_mode == MODE_SOFT) begin
      num     <= NUM_W'({w, 12'b0}) + NUM_W'(total >> 1);
      rem     <= '0;
      div_cnt <= '0;
      d_index <= 6'(s4_idx);
      d_last  <= s4_last;
    end else if (div_busy) begin
      num     <= num_next;
      rem     <= rem_next;
      div_cnt <= div_cnt + 1'b1;
      if (div_cnt == DIV_CNT_W'(NUM_W - 1)) begin
        out_index <= d_index;
        out_value <= num_next[VAL_W-1:0];
        out_last  <= d_last;
      end
    end
  end

endmodule

FILE: src/dlls_ctrl.sv
// Sequencer of the dense layer unit: configuration registers, load
// handshake and the per-neuron command schedule. Depends on dlls_pkg.
module dlls_ctrl
  import dlls_pkg::*;
#(
  parameter int OUT_MAX = 64,
  parameter int ROW_W   = 6,
  parameter int AW      = 8,
  parameter int LEN_W   = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       command,
  input  logic             last,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_value,
  input  logic [LEN_W-1:0] len,
  input  dp_stat_t         stat,
  output logic             busy,
  output dp_cmd_t          cmd,
  output logic [ROW_W-1:0] idx,
  output logic [AW-1:0]    col_sel,
  output logic [15:0]      slope
);

  localparam int CNT_W = $clog2(OUT_MAX + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_BIAS, S_MAC, S_DRAIN, S_LEAKY, S_MAXP, S_TOT, S_SOFT, S_SWAIT, S_WAIT
  } state_t;

  state_t           state, wait_next;
  logic             act_mode;
  logic [6:0]       out_count;
  logic [CNT_W-1:0] n;
  logic [ROW_W-1:0] i;
  logic [AW-1:0]    j;
  logic [2:0]       cnt;
  logic             last_i, last_j;

  assign cfg_ready = 1'b1;
  assign busy      = state != S_IDLE;

  always_comb begin
    if (out_count == '0) begin
      n = CNT_W'(1);
    end else if (32'(out_count) > OUT_MAX) begin
      n = CNT_W'(OUT_MAX);
    end else begin
      n = CNT_W'(out_count);
    end
    last_i = CNT_W'(i) + 1'b1 == n;
    last_j = LEN_W'(j) + 1'b1 == len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_mode  <= 1'b0;
      out_count <= 7'd64;
      slope     <= 16'd655;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACT_MODE:  act_mode  <= cfg_value[0];
        REG_OUT_COUNT: out_count <= cfg_value[6:0];
        REG_SLOPE:     slope     <= cfg_value;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wait_next <= S_IDLE;
      cmd       <= '0;
      i         <= '0;
      j         <= '0;
      cnt       <= '0;
      idx       <= '0;
      col_sel   <= '0;
    end else begin
      cmd <= '0;
      unique case (state)
        S_IDLE: begin
          if (start && command == CMD_ACT && last) begin
            state <= S_BIAS;
            i     <= '0;
          end
        end
        S_BIAS: begin
          cmd.bias_rd <= 1'b1;
          cmd.empty   <= len == '0;
          idx         <= i;
          j           <= '0;
          cnt         <= '0;
          state       <= (len == '0) ? S_DRAIN : S_MAC;
        end
        S_MAC: begin
          cmd.mac     <= 1'b1;
          cmd.mac_end <= last_j;
          idx         <= i;
          col_sel     <= j;
          j           <= j + 1'b1;
          if (last_j) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          cnt <= cnt + 1'b1;
          if (cnt == 3'd3) begin
            cnt <= '0;
            if (last_i) begin
              cmd.clr_len <= 1'b1;
              i           <= '0;
              state       <= act_mode ? S_MAXP : S_LEAKY;
            end else begin
              i     <= i + 1'b1;
              state <= S_BIAS;
            end
          end
        end
        S_LEAKY: begin
          cmd.sum_rd <= 1'b1;
          cmd.mode   <= MODE_LEAKY;
          cmd.last   <= last_i;
          idx        <= i;
          i          <= i + 1'b1;
          if (last_i) begin
            cnt       <= '0;
            wait_next <= S_IDLE;
            state     <= S_WAIT;
          end
        end
        S_MAXP: begin
          cmd.sum_rd <= 1'b1;
          cmd.mode   <= MODE_MAX;
          cmd.first  <= i == '0;
          idx        <= i;
          i          <= i + 1'b1;
          if (last_i) begin
            i         <= '0;
            cnt       <= '0;
            wait_next <= S_TOT;
            state     <= S_WAIT;
          end
        end
        S_TOT: begin
          cmd.sum_rd <= 1'b1;
          cmd.mode   <= MODE_TOTAL;
          cmd.first  <= i == '0;
          idx        <= i;
          i          <= i + 1'b1;
          if (last_i) begin
            i         <= '0;
            cnt       <= '0;
            wait_next <= S_SOFT;
            state     <= S_WAIT;
          end
        end
        S_SOFT: begin
          cmd.sum_rd <= 1'b1;
          cmd.mode   <= MODE_SOFT;
          cmd.last   <= last_i;
          idx        <= i;
          state      <= S_SWAIT;
        end
        S_SWAIT: begin
          if (stat.div_done) begin
            if (last_i) begin
              cnt       <= '0;
              wait_next <= S_IDLE;
              state     <= S_WAIT;
            end else begin
              i     <= i + 1'b1;
              state <= S_SOFT;
            end
          end
        end
        S_WAIT: begin
          cnt <= cnt + 1'b1;
          if (cnt == 3'd7) begin
            state <= wait_next;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/dense_layer_leaky_softmax_unit.sv
// Top level of the dense layer unit: sequencer plus datapath.
// Depends on dlls_pkg, dlls_ctrl and dlls_dp.
//
// Weight, bias and activation beats are taken one per cycle while busy is
// low. The activation beat flagged last starts the layer and raises busy:
// each neuron is summed in turn on the single MAC. Leaky ReLU then emits
// one result per cycle; softmax makes three passes over the sums (max,
// total, outputs) and each output waits for the serial divider before the
// next is started. Results leave as single-cycle strobes that the receiver
// cannot stall; busy drops after the last one. Configuration writes are
// taken at any time but belong in idle periods.
module dense_layer_leaky_softmax_unit
  import dlls_pkg::*;
#(
  parameter int OUT_MAX = 64,
  parameter int IN_MAX  = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              command,
  input  logic [5:0]              row,
  input  logic [7:0]              col,
  input  logic signed [VAL_W-1:0] value,
  input  logic                    last,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_value,
  output logic                    strobe,
  output logic [5:0]              out_index,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_last
);

  localparam int ROW_W = OUT_MAX > 1 ? $clog2(OUT_MAX) : 1;
  localparam int AW    = IN_MAX > 1 ? $clog2(IN_MAX) : 1;
  localparam int LEN_W = $clog2(IN_MAX + 1);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [ROW_W-1:0] idx;
  logic [AW-1:0]    col_sel;
  logic [15:0]      slope;
  logic [LEN_W-1:0] len;
  logic             accept;

  assign accept = start && !busy;

  dlls_ctrl #(
    .OUT_MAX(OUT_MAX), .ROW_W(ROW_W), .AW(AW), .LEN_W(LEN_W)
  ) u_ctrl (
    .clk, .rst, .start, .command, .last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_value,
    .len, .stat, .busy, .cmd, .idx, .col_sel, .slope
  );

  dlls_dp #(
    .OUT_MAX(OUT_MAX), .IN_MAX(IN_MAX), .ROW_W(ROW_W), .AW(AW), .LEN_W(LEN_W)
  ) u_dp (
    .clk, .rst, .accept, .cmd, .idx, .col_sel, .slope,
    .command, .row, .col, .value,
    .len, .stat, .strobe, .out_index, .out_value, .out_last
  );

endmodule

FILE: src/dlls_chk.sv
// Port-level checker for the dense layer unit, bound to the top level.
// Depends on dlls_pkg and dense_layer_leaky_softmax_unit.
module dlls_chk
  import dlls_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] command,
  input logic       last,
  input logic       strobe,
  input logic       out_last
);

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("result beat while idle");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && out_last |=> !strobe)
    else $error("result beat after final beat");

  a_reset: assert property (@(posedge clk) rst |=> !busy && !strobe)
    else $error("busy or result beat after reset");

  a_launch: assert property (@(posedge clk) disable iff (rst)
    start && !busy && command == CMD_ACT && last |=> busy)
    else $error("final activation did not start the layer");

endmodule

bind dense_layer_leaky_softmax_unit dlls_chk u_chk (.*);

FILE: sim/dense_layer_leaky_softmax_unit_tb.sv
// Self-checking testbench for dense_layer_leaky_softmax_unit.
// Drives weight, bias and activation beats plus register writes, predicts every
// neuron output with a local fixed-point model. Depends on dlls_pkg and the RTL.
`timescale 1ns / 100ps

typedef struct {
  logic [5:0]        index;
  logic signed [15:0] value;
  logic              last;
} neuron_out_t;

class layer_checker;
  shortint     weights[64][256];
  shortint     biases[64];
  shortint     acts[256];
  longint      sums[64];
  int unsigned vec_len;
  bit          soft_mode;
  int unsigned out_count;
  int unsigned slope;
  neuron_out_t expected_outputs[$];
  int          errors;
  int unsigned results_seen;
  int unsigned vectors_seen;
  int unsigned exp_int[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
  int unsigned exp_frac[16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
                                39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};

  function new();
    foreach (biases[i]) biases[i] = 0;
    vec_len = 0;
    soft_mode = 0;
    out_count = 64;
    slope = 655;
    errors = 0;
    results_seen = 0;
    vectors_seen = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] data);
    if (idx == dlls_pkg::REG_ACT_MODE) soft_mode = data[0];
    else if (idx == dlls_pkg::REG_OUT_COUNT) out_count = data[6:0];
    else if (idx == dlls_pkg::REG_SLOPE) slope = data;
  endfunction

  function longint clamp40(longint v);
    longint hi;
    hi = (longint'(1) <<< 39) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function longint q12(longint v);
    longint q;
    q = (v + 2048) >>> 12;
    if (q > 32767) return 32767;
    if (q < -32768) return -32768;
    return q;
  endfunction

  function longint exp_weight(longint diff);
    longint d;
    longint e;
    d = diff >>> 12;
    if (d >= (12 <<< 12)) return 0;
    e = (longint'(exp_int[d >> 12]) * exp_frac[(d >> 8) & 15] + 32768) >> 16;
    e = (e * (65536 - 16 * (d & 255)) + 32768) >> 16;
    return e;
  endfunction

  function void note_beat(logic [1:0] cmd, logic [5:0] r, logic [7:0] c,
                          logic signed [15:0] v, logic lst);
    int unsigned n;
    longint acc;
    longint mx;
    longint total;
    longint y;
    neuron_out_t o;
    if (cmd == dlls_pkg::CMD_WEIGHT) weights[r][c] = v;
    else if (cmd == dlls_pkg::CMD_BIAS) biases[r] = v;
    else if (cmd == dlls_pkg::CMD_ACT) begin
      acts[c] = v;
      if (vec_len < 256) vec_len++;
      if (lst) begin
        n = (out_count == 0) ? 1 : ((out_count > 64) ? 64 : out_count);
        for (int i = 0; i < n; i++) begin
          acc = longint'(biases[i]) * 4096;
          for (int j = 0; j < vec_len; j++)
            acc = clamp40(acc + longint'(weights[i][j]) * longint'(acts[j]));
          sums[i] = acc;
        end
        mx = sums[0];
        total = 0;
        for (int i = 1; i < n; i++) if (sums[i] > mx) mx = sums[i];
        for (int i = 0; i < n; i++) total += exp_weight(mx - sums[i]);
        for (int i = 0; i < n; i++) begin
          o.index = i;
          o.last = (i == n - 1);
          if (!soft_mode) begin
            y = sums[i];
            if (y < 0) y = (y * longint'(slope)) >>> 16;
            o.value = q12(y);
          end else begin
            y = exp_weight(mx - sums[i]);
            o.value = (total != 0) ? (y * 4096 + total / 2) / total : 0;
          end
          expected_outputs.push_back(o);
        end
        vec_len = 0;
        vectors_seen++;
      end
    end
  endfunction

  function void check_result(logic [5:0] idx, logic signed [15:0] v, logic lst);
    neuron_out_t e;
    results_seen++;
    if (expected_outputs.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result: index %0d value %0d last %0b", idx, v, lst);
      return;
    end
    e = expected_outputs.pop_front();
    if (idx !== e.index || v !== e.value || lst !== e.last) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp index %0d value %0d last %0b, got index %0d value %0d last %0b",
                 e.index, e.value, e.last, idx, v, lst);
    end
  endfunction
endclass

module dense_layer_leaky_softmax_unit_tb;
  import dlls_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [1:0] command = '0;
  logic [5:0] row = '0;
  logic [7:0] col = '0;
  logic signed [15:0] value = '0;
  logic last = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_value = '0;
  logic strobe;
  logic [5:0] out_index;
  logic signed [15:0] out_value;
  logic out_last;

  layer_checker chk = new();
  bit w_ok[64][256];
  bit a_ok[256];
  int unsigned cur_n = 64;
  bit quiet = 0;
  int unsigned cycles = 0;
  int unsigned beats = 0;

  dense_layer_leaky_softmax_unit uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (!rst) begin
      if (start && !busy) begin
        chk.note_beat(command, row, col, value, last);
        beats++;
      end
      if (cfg_valid && cfg_ready) chk.write_reg(cfg_index, cfg_value);
      if (strobe) chk.check_result(out_index, out_value, out_last);
    end
  end

  task automatic send(logic [1:0] c, logic [5:0] r, logic [7:0] k,
                      logic signed [15:0] v, logic l);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start <= 1;
    command <= c;
    row <= r;
    col <= k;
    value <= v;
    last <= l;
    do @(posedge clk); while (busy);
    if (c == CMD_WEIGHT) w_ok[r][k] = 1;
    else if (c == CMD_ACT) a_ok[k] = 1;
  endtask

  task automatic drain();
    start <= 0;
    do @(posedge clk); while (chk.expected_outputs.size() != 0 || busy);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    start <= 0;
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_value <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
    if (idx == REG_OUT_COUNT)
      cur_n = (data[6:0] == 0) ? 1 : ((data[6:0] > 64) ? 64 : data[6:0]);
  endtask

  function automatic logic signed [15:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return $urandom_range(0, 8191) - 4096;
      default: return $urandom;
    endcase
  endfunction

  task automatic noise();
    case ($urandom_range(0, 3))
      0: send(CMD_WEIGHT, $urandom, $urandom, rand_val(), $urandom);
      1: send(CMD_BIAS, $urandom, $urandom, rand_val(), $urandom);
      default: send(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
    endcase
  endtask

  // send one vector, filling any weight or activation it would read unwritten
  task automatic vector(int unsigned len, bit noisy);
    int unsigned cols[];
    bit seen[256];
    bit ok;
    cols = new[len];
    seen = a_ok;
    foreach (cols[k]) begin
      cols[k] = (noisy && $urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : k % 256;
      seen[cols[k]] = 1;
    end
    ok = 1;
    for (int j = 0; j < len && j < 256; j++) if (!seen[j]) ok = 0;
    if (!ok) foreach (cols[k]) cols[k] = k % 256;
    for (int i = 0; i < cur_n; i++)
      for (int j = 0; j < len && j < 256; j++)
        if (!w_ok[i][j]) send(CMD_WEIGHT, i, j, rand_val(), $urandom);
    foreach (cols[k]) begin
      if (noisy && $urandom_range(0, 7) == 0) noise();
      send(CMD_ACT, $urandom, cols[k], rand_val(), k == len - 1);
    end
  endtask

  task automatic random_phase(int unsigned count, int unsigned max_len);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) noise();
      else vector($urandom_range(1, max_len), 1);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extreme biases, extreme weights, reset settings, ignored commands
    send(CMD_BIAS, 0, 0, 16'sh7FFF, 1);
    send(CMD_BIAS, 63, 255, 16'sh8000, 0);
    send(CMD_UNUSED, 63, 255, 16'sh7FFF, 1);
    send(CMD_WEIGHT, 63, 255, 16'sh8000, 1);
    write_reg(REG_OUT_COUNT, 16'd2);
    send(CMD_WEIGHT, 0, 0, 16'sh7FFF, 0);
    send(CMD_WEIGHT, 1, 0, 16'sh8000, 0);
    send(CMD_WEIGHT, 0, 1, 16'sh8000, 0);
    send(CMD_WEIGHT, 1, 1, 16'sh7FFF, 0);
    send(CMD_ACT, 0, 0, 16'sh8000, 0);
    send(CMD_ACT, 0, 1, 16'sh7FFF, 1);
    drain();
    write_reg(REG_ACT_MODE, 16'd1);
    send(CMD_ACT, 0, 1, 16'sh8000, 0);
    send(CMD_ACT, 0, 0, 16'sh8000, 1);
    drain();
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(REG_OUT_COUNT, 16'd0);
    vector(2, 0);
    drain();

    write_reg(REG_ACT_MODE, 16'hFFFE);
    write_reg(REG_OUT_COUNT, 16'd64);
    random_phase(2, 1);
    drain();
    write_reg(REG_SLOPE, 16'd0);
    write_reg(REG_OUT_COUNT, 16'd1);
    random_phase(4, 3);
    drain();
    write_reg(REG_SLOPE, 16'hFFFF);
    write_reg(REG_OUT_COUNT, 16'd200);
    random_phase(2, 1);
    drain();
    write_reg(REG_ACT_MODE, 16'd1);
    write_reg(REG_OUT_COUNT, 16'd100);
    random_phase(2, 1);
    drain();
    write_reg(REG_OUT_COUNT, $urandom_range(1, 64));
    write_reg(REG_SLOPE, $urandom);
    random_phase(3, 1);
    drain();

    // leaky mode on a single neuron with a random slope
    write_reg(REG_ACT_MODE, 16'd0);
    write_reg(REG_OUT_COUNT, 16'd1);
    write_reg(REG_SLOPE, $urandom);
    vector(4, 0);
    drain();

    quiet = 1;
    write_reg(REG_OUT_COUNT, $urandom_range(1, 16));
    random_phase(4, 1);
    drain();

    $display("covered %0d input beats, %0d vectors, %0d neuron results",
             beats, chk.vectors_seen, chk.results_seen);
    $display("both activation modes, output counts 1..64 and clamped, slopes 0..65535");
    if (chk.errors == 0 && chk.expected_outputs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", chk.errors, chk.expected_outputs.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
